[rtl/core/odo_pkg.sv]
// Shared types, widths, constants and the arctangent table of the odometry block.
`timescale 1ns / 1ps
package odo_pkg;

   localparam int CORDIC_STEPS_DEF = 20;

   localparam int GAIN_W  = 26;
   localparam int SPEED_W = 24;
   localparam int RATE_W  = 24;
   localparam int TIME_W  = 32;
   localparam int POS_W   = 32;
   localparam int ANG_W   = 24;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_ARC   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_ARC  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_TURN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_TURN = 2'd3;

   localparam logic [GAIN_W-1:0] LEFT_ARC_RST   = 26'd1996489;
   localparam logic [GAIN_W-1:0] RIGHT_ARC_RST  = 26'd1996371;
   localparam logic [GAIN_W-1:0] LEFT_TURN_RST  = 26'd4917671;
   localparam logic [GAIN_W-1:0] RIGHT_TURN_RST = 26'd4917386;

   localparam logic [POS_W-1:0] POS_X_RST   = 32'hFFF9_8000;
   localparam logic [POS_W-1:0] POS_Y_RST   = 32'h0011_0000;
   localparam logic [ANG_W-1:0] HEADING_RST = 24'h80_0000;

   // Serial multiplier operand and product widths.
   localparam int MUL_A_W = 64;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Wheel sum and turn difference, and their scaling shifts.
   localparam int V_W          = 52;
   localparam int TRAVEL_SHIFT = 12;
   localparam int HEAD_SHIFT   = 40;
   localparam int DX_SHIFT     = 38;
   localparam int YAW_SHIFT    = 24;
   localparam int SPEED_SHIFT  = 25;
   localparam int DMAG_W       = 33;
   localparam int STEP_W       = 43;
   localparam int SUM_W        = 44;
   localparam int DIST_W       = 48;
   localparam int DT_W         = 24;
   localparam logic [31:0] HEAD_K = 32'd2799883369;

   // Travel divider: dividend width, remainder width and the divisor.
   localparam int DIV_N_W = 63;
   localparam int DIV_R_W = 15;
   localparam logic [DIV_R_W-1:0] DIST_DIV = 15'd32000;

   // CORDIC datapath.
   localparam int COR_W      = 34;
   localparam int ATAN_IDX_W = 5;
   localparam logic signed [COR_W-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   function automatic logic [31:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h2000_0000;
         5'd1:  r = 32'h12E4_051E;
         5'd2:  r = 32'h09FB_385B;
         5'd3:  r = 32'h0511_11D4;
         5'd4:  r = 32'h028B_0D43;
         5'd5:  r = 32'h0145_D7E1;
         5'd6:  r = 32'h00A2_F61E;
         5'd7:  r = 32'h0051_7C55;
         5'd8:  r = 32'h0028_BE53;
         5'd9:  r = 32'h0014_5F2F;
         5'd10: r = 32'h000A_2F98;
         5'd11: r = 32'h0005_17CC;
         5'd12: r = 32'h0002_8BE6;
         5'd13: r = 32'h0001_45F3;
         5'd14: r = 32'h0000_A2FA;
         5'd15: r = 32'h0000_517D;
         5'd16: r = 32'h0000_28BE;
         5'd17: r = 32'h0000_145F;
         5'd18: r = 32'h0000_0A30;
         5'd19: r = 32'h0000_0518;
         5'd20: r = 32'h0000_028C;
         5'd21: r = 32'h0000_0146;
         5'd22: r = 32'h0000_00A3;
         5'd23: r = 32'h0000_0051;
         5'd24: r = 32'h0000_0029;
         5'd25: r = 32'h0000_0014;
         5'd26: r = 32'h0000_000A;
         5'd27: r = 32'h0000_0005;
         5'd28: r = 32'h0000_0003;
         5'd29: r = 32'h0000_0001;
         5'd30: r = 32'h0000_0001;
         default: r = 32'h0000_0000;
      endcase
      return r;
   endfunction

endpackage

[rtl/core/odo_mul.sv]
// Shift-add multiplier that retires one bit of the second operand per cycle.
`timescale 1ns / 1ps
module odo_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  odo_pkg::mul_req_type          req,
   output logic                          done,
   output logic [odo_pkg::MUL_P_W-1:0]   product
);
   import odo_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W);

   logic [MUL_A_W-1:0] a_ff, a_in;
   logic [MUL_A_W-1:0] hi_ff, hi_in;
   logic [MUL_B_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [MUL_A_W:0]   sum;

   always_comb begin
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         a_in    = req.a;
         hi_in   = '0;
         lo_in   = req.b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[MUL_A_W:1];
         lo_in  = {sum[0], lo_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

[rtl/core/odo_div.sv]
// Restoring divider by the travel constant, one quotient bit per cycle.
`timescale 1ns / 1ps
module odo_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [odo_pkg::DIV_N_W-1:0]   numer,
   output logic                          done,
   output logic [odo_pkg::DIV_N_W-1:0]   quot
);
   import odo_pkg::*;

   localparam int CNT_W = $clog2(DIV_N_W);

   logic [DIV_N_W-1:0] n_ff, n_in;
   logic [DIV_R_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIV_R_W:0]   trial;
   logic [DIV_R_W:0]   diff;
   logic               ge;

   always_comb begin
      trial   = {rem_ff, n_ff[DIV_N_W-1]};
      diff    = trial - {1'b0, DIST_DIV};
      ge      = trial >= {1'b0, DIST_DIV};
      n_in    = n_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = numer;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_R_W-1:0] : trial[DIV_R_W-1:0];
         n_in   = {n_ff[DIV_N_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = n_ff;

endmodule

[rtl/core/odo_cordic.sv]
// Iterative CORDIC rotator giving cosine and sine of a 32-bit binary angle.
`timescale 1ns / 1ps
module odo_cordic #(
   parameter int STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [31:0]                         angle,
   output logic                                done,
   output logic signed [odo_pkg::COR_W-1:0]    cos_out,
   output logic signed [odo_pkg::COR_W-1:0]    sin_out
);
   import odo_pkg::*;

   logic signed [COR_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [COR_W-1:0] xs, ys, at;
   logic [ATAN_IDX_W-1:0]   idx_ff, idx_in;
   logic                    flip_ff, flip_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [31:0]             ang_rot, ang_fold;

   always_comb begin
      // Angles in the back half-plane are turned by half a circle first.
      ang_rot  = angle + 32'h4000_0000;
      ang_fold = ang_rot[31] ? (angle ^ 32'h8000_0000) : angle;
      xs       = x_ff >>> idx_ff;
      ys       = y_ff >>> idx_ff;
      at       = $signed({{(COR_W-32){1'b0}}, atan_lookup(idx_ff)});
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      idx_in   = idx_ff;
      flip_in  = flip_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = $signed({{(COR_W-32){ang_fold[31]}}, ang_fold});
         idx_in  = '0;
         flip_in = ang_rot[31];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[COR_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         idx_in = idx_ff + 1'b1;
         if (idx_ff == ATAN_IDX_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      idx_ff  <= idx_in;
      flip_ff <= flip_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule

[rtl/core/diff_drive_odometry.sv]
// Dead-reckoning pose tracker for a two-wheel robot, top level.
// A wheel sample that moves the pose runs nine passes of the serial multiplier, the travel
// divider and the CORDIC. Set pose, a repeated timestamp and the first sample go straight
// to the finishing state. One item is in flight at a time.
// Synchronous active-high reset restores the gains, the start pose and clears the rates.
`timescale 1ns / 1ps
module diff_drive_odometry #(
   parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic signed [odo_pkg::SPEED_W-1:0]   req_left_speed,
   input  logic signed [odo_pkg::SPEED_W-1:0]   req_right_speed,
   input  logic [odo_pkg::TIME_W-1:0]           req_time_ms,
   input  logic signed [odo_pkg::POS_W-1:0]     req_new_x,
   input  logic signed [odo_pkg::POS_W-1:0]     req_new_y,
   input  logic signed [odo_pkg::ANG_W-1:0]     req_new_heading,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [odo_pkg::POS_W-1:0]     rsp_pose_x,
   output logic signed [odo_pkg::POS_W-1:0]     rsp_pose_y,
   output logic signed [odo_pkg::ANG_W-1:0]     rsp_heading,
   output logic [odo_pkg::RATE_W-1:0]           rsp_speed,
   output logic signed [odo_pkg::RATE_W-1:0]    rsp_yaw_rate,
   output logic [odo_pkg::TIME_W-1:0]           rsp_update_time_ms,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [odo_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [odo_pkg::GAIN_W-1:0]           csr_wdata
);
   import odo_pkg::*;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_COR  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   // Multiplier passes, in the order they run.
   typedef enum logic [3:0] {
      OP_LEFT_ARC,
      OP_RIGHT_ARC,
      OP_RIGHT_TURN,
      OP_LEFT_TURN,
      OP_HEAD_TIME,
      OP_HEAD_GAIN,
      OP_TRAVEL,
      OP_DX,
      OP_DY
   } op_type;

   // What the finishing cycle does to the state.
   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_HOLD,
      KIND_FIRST,
      KIND_MOVE
   } kind_type;

   localparam logic [RATE_W-1:0] YAW_MAX = {1'b0, {(RATE_W-1){1'b1}}};
   localparam logic [RATE_W-1:0] YAW_NEG = {1'b1, {(RATE_W-1){1'b0}}};
   localparam logic [POS_W-1:0]  POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic [POS_W-1:0]  POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   // Saturate a widened position sum back to the position width.
   function automatic logic [POS_W-1:0] sat_pos(input logic [SUM_W-1:0] v);
      logic [POS_W-1:0] r;
      if ((&v[SUM_W-1:POS_W-1]) || !(|v[SUM_W-1:POS_W-1])) begin
         r = v[POS_W-1:0];
      end else begin
         r = v[SUM_W-1] ? POS_MIN : POS_MAX;
      end
      return r;
   endfunction

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   kind_type  kind_ff, kind_in;
   logic      mul_start_ff, mul_start_in;
   logic      div_start_ff, div_start_in;
   logic      cor_start_ff, cor_start_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Gains.
   logic [GAIN_W-1:0] lag_ff, lag_in, rag_ff, rag_in, ltg_ff, ltg_in, rtg_ff, rtg_in;

   // Architectural state; it also drives the result ports.
   logic [POS_W-1:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [ANG_W-1:0]  head_ff, head_in;
   logic [RATE_W-1:0] speed_ff, speed_in, yaw_ff, yaw_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic              started_ff, started_in;

   // Captured beat and per-item working registers.
   logic [SPEED_W-1:0] vl_ff, vl_in, vr_ff, vr_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [POS_W-1:0]   nx_ff, nx_in, ny_ff, ny_in;
   logic [ANG_W-1:0]   nh_ff, nh_in;
   logic               dneg_ff, dneg_in;
   logic [DT_W-1:0]    adt_ff, adt_in;
   logic signed [V_W-1:0] v_ff, v_in, w_ff, w_in;
   logic [ANG_W-1:0]   headn_ff, headn_in;
   logic [31:0]        ang_ff, ang_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic [31:0]        cmag_ff, cmag_in, smag_ff, smag_in;
   logic               cneg_ff, cneg_in, sneg_ff, sneg_in;
   logic [POS_W-1:0]   px_ff, px_in, py_ff, py_in;

   // Datapath helpers.
   mul_req_type            mul_req;
   logic                   mul_done, div_done, cor_done;
   logic [MUL_P_W-1:0]     mul_prod;
   logic [DIV_N_W-1:0]     div_quot;
   logic signed [COR_W-1:0] cor_cos, cor_sin, neg_cos, neg_sin;
   logic [SPEED_W-1:0]     vl_mag, vr_mag;
   logic                   vl_neg, vr_neg;
   logic signed [V_W-1:0]  p_vw;
   logic [V_W-1:0]         v_mag, w_mag;
   logic [TIME_W:0]        dt, dt_mag;
   logic [DMAG_W-1:0]      dmag;
   logic                   tneg, vneg;
   logic [31:0]            dth, dhalf, h32, head_sum;
   logic [STEP_W-1:0]      m_step;
   logic [SUM_W-1:0]       step_x, step_y, sum_x, sum_y;
   logic [V_W-YAW_SHIFT-1:0]   wm;
   logic [V_W-SPEED_SHIFT-1:0] sm;
   logic [RATE_W-1:0]      yaw_new, speed_new, wm_clip;
   logic                   fin_go;

   always_comb begin
      vl_neg  = vl_ff[SPEED_W-1];
      vl_mag  = vl_neg ? (~vl_ff + 1'b1) : vl_ff;
      // The right wheel speed is negated, so its sign is the reverse of the beat's.
      vr_neg  = !vr_ff[SPEED_W-1];
      vr_mag  = vr_ff[SPEED_W-1] ? (~vr_ff + 1'b1) : vr_ff;
      p_vw    = $signed(mul_prod[V_W-1:0]);
      v_mag   = v_ff[V_W-1] ? V_W'(-v_ff) : V_W'(v_ff);
      w_mag   = w_ff[V_W-1] ? V_W'(-w_ff) : V_W'(w_ff);
      dt      = {1'b0, req_time_ms} - {1'b0, last_time_ff};
      dt_mag  = dt[TIME_W] ? (~dt + 1'b1) : dt;
      dmag    = mul_prod[HEAD_SHIFT +: DMAG_W];
      tneg    = w_ff[V_W-1] ^ dneg_ff;
      vneg    = v_ff[V_W-1] ^ dneg_ff;
      dth     = tneg ? (32'd0 - dmag[31:0]) : dmag[31:0];
      dhalf   = tneg ? (32'd0 - dmag[DMAG_W-1:1]) : dmag[DMAG_W-1:1];
      h32     = {head_ff, 8'd0};
      head_sum = h32 + dth;
      m_step  = mul_prod[DX_SHIFT +: STEP_W];
      step_x  = (cneg_ff ^ vneg) ? (SUM_W'(0) - {1'b0, m_step}) : {1'b0, m_step};
      step_y  = (sneg_ff ^ vneg) ? (SUM_W'(0) - {1'b0, m_step}) : {1'b0, m_step};
      sum_x   = {{(SUM_W-POS_W){pos_x_ff[POS_W-1]}}, pos_x_ff} + step_x;
      sum_y   = {{(SUM_W-POS_W){pos_y_ff[POS_W-1]}}, pos_y_ff} + step_y;
      neg_cos = -cor_cos;
      neg_sin = -cor_sin;

      // Yaw rate and speed, saturated to the result widths.
      wm      = w_mag[V_W-1:YAW_SHIFT];
      wm_clip = (wm > (V_W-YAW_SHIFT)'(YAW_NEG)) ? YAW_NEG : wm[RATE_W-1:0];
      if (w_ff[V_W-1]) begin
         yaw_new = RATE_W'(0) - wm_clip;
      end else begin
         yaw_new = (wm > (V_W-YAW_SHIFT)'(YAW_MAX)) ? YAW_MAX : wm[RATE_W-1:0];
      end
      sm        = v_mag[V_W-1:SPEED_SHIFT];
      speed_new = (|sm[V_W-SPEED_SHIFT-1:RATE_W]) ? '1 : sm[RATE_W-1:0];
      if (dneg_ff) begin
         speed_new = '0;
      end
   end

   // Operands of the shared multiplier for each pass.
   always_comb begin
      mul_req.start = mul_start_ff;
      case (op_ff)
         OP_LEFT_ARC: begin
            mul_req.a = MUL_A_W'(lag_ff);
            mul_req.b = MUL_B_W'(vl_mag);
         end
         OP_RIGHT_ARC: begin
            mul_req.a = MUL_A_W'(rag_ff);
            mul_req.b = MUL_B_W'(vr_mag);
         end
         OP_RIGHT_TURN: begin
            mul_req.a = MUL_A_W'(rtg_ff);
            mul_req.b = MUL_B_W'(vr_mag);
         end
         OP_LEFT_TURN: begin
            mul_req.a = MUL_A_W'(ltg_ff);
            mul_req.b = MUL_B_W'(vl_mag);
         end
         OP_HEAD_TIME: begin
            mul_req.a = MUL_A_W'(w_mag >> TRAVEL_SHIFT);
            mul_req.b = MUL_B_W'(adt_ff);
         end
         OP_HEAD_GAIN: begin
            // The previous product is still held in the multiplier.
            mul_req.a = mul_prod[MUL_A_W-1:0];
            mul_req.b = HEAD_K;
         end
         OP_TRAVEL: begin
            mul_req.a = MUL_A_W'(v_mag >> TRAVEL_SHIFT);
            mul_req.b = MUL_B_W'(adt_ff);
         end
         OP_DX: begin
            mul_req.a = MUL_A_W'(dist_ff);
            mul_req.b = cmag_ff;
         end
         OP_DY: begin
            mul_req.a = MUL_A_W'(dist_ff);
            mul_req.b = smag_ff;
         end
         default: begin
            mul_req.a = '0;
            mul_req.b = '0;
         end
      endcase
   end

   // Sequencer and working registers.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      kind_in      = kind_ff;
      mul_start_in = 1'b0;
      div_start_in = 1'b0;
      cor_start_in = 1'b0;
      vl_in        = vl_ff;
      vr_in        = vr_ff;
      time_in      = time_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      nh_in        = nh_ff;
      dneg_in      = dneg_ff;
      adt_in       = adt_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      headn_in     = headn_ff;
      ang_in       = ang_ff;
      dist_in      = dist_ff;
      cmag_in      = cmag_ff;
      smag_in      = smag_ff;
      cneg_in      = cneg_ff;
      sneg_in      = sneg_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      fin_go       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               vl_in   = req_left_speed;
               vr_in   = req_right_speed;
               time_in = req_time_ms;
               nx_in   = req_new_x;
               ny_in   = req_new_y;
               nh_in   = req_new_heading;
               dneg_in = dt[TIME_W];
               // Elapsed time magnitude saturates for the pose step.
               adt_in  = (|dt_mag[TIME_W:DT_W]) ? '1 : dt_mag[DT_W-1:0];
               if (req_command) begin
                  kind_in  = KIND_LOAD;
                  state_in = ST_FIN;
               end else if (dt == '0) begin
                  kind_in  = KIND_HOLD;
                  state_in = ST_FIN;
               end else if (!started_ff) begin
                  kind_in  = KIND_FIRST;
                  state_in = ST_FIN;
               end else begin
                  kind_in      = KIND_MOVE;
                  state_in     = ST_MUL;
                  op_in        = OP_LEFT_ARC;
                  mul_start_in = 1'b1;
               end
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               case (op_ff)
                  OP_LEFT_ARC: begin
                     v_in         = vl_neg ? -p_vw : p_vw;
                     op_in        = OP_RIGHT_ARC;
                     mul_start_in = 1'b1;
                  end
                  OP_RIGHT_ARC: begin
                     v_in         = v_ff + (vr_neg ? -p_vw : p_vw);
                     op_in        = OP_RIGHT_TURN;
                     mul_start_in = 1'b1;
                  end
                  OP_RIGHT_TURN: begin
                     w_in         = vr_neg ? -p_vw : p_vw;
                     op_in        = OP_LEFT_TURN;
                     mul_start_in = 1'b1;
                  end
                  OP_LEFT_TURN: begin
                     w_in         = w_ff - (vl_neg ? -p_vw : p_vw);
                     op_in        = OP_HEAD_TIME;
                     mul_start_in = 1'b1;
                  end
                  OP_HEAD_TIME: begin
                     op_in        = OP_HEAD_GAIN;
                     mul_start_in = 1'b1;
                  end
                  OP_HEAD_GAIN: begin
                     // New heading, and the mid-step angle for the rotator.
                     headn_in     = head_sum[31:8];
                     ang_in       = h32 + dhalf;
                     op_in        = OP_TRAVEL;
                     mul_start_in = 1'b1;
                  end
                  OP_TRAVEL: begin
                     state_in     = ST_DIV;
                     div_start_in = 1'b1;
                  end
                  OP_DX: begin
                     px_in        = sat_pos(sum_x);
                     op_in        = OP_DY;
                     mul_start_in = 1'b1;
                  end
                  OP_DY: begin
                     py_in    = sat_pos(sum_y);
                     state_in = ST_FIN;
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               dist_in      = div_quot[DIST_W-1:0];
               state_in     = ST_COR;
               cor_start_in = 1'b1;
            end
         end
         ST_COR: begin
            if (cor_done) begin
               cneg_in      = cor_cos[COR_W-1];
               sneg_in      = cor_sin[COR_W-1];
               cmag_in      = cor_cos[COR_W-1] ? neg_cos[31:0] : cor_cos[31:0];
               smag_in      = cor_sin[COR_W-1] ? neg_sin[31:0] : cor_sin[31:0];
               state_in     = ST_MUL;
               op_in        = OP_DX;
               mul_start_in = 1'b1;
            end
         end
         ST_FIN: begin
            // The state doubles as the result register, so it changes only
            // once the previous result beat has gone.
            if (!rsp_valid_ff || rsp_ready) begin
               fin_go   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Architectural state update at the end of an item.
   always_comb begin
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      head_in      = head_ff;
      speed_in     = speed_ff;
      yaw_in       = yaw_ff;
      last_time_in = last_time_ff;
      started_in   = started_ff;
      if (fin_go) begin
         case (kind_ff)
            KIND_LOAD: begin
               pos_x_in = nx_ff;
               pos_y_in = ny_ff;
               head_in  = nh_ff;
            end
            KIND_HOLD: begin
               started_in = 1'b1;
            end
            KIND_FIRST: begin
               started_in   = 1'b1;
               last_time_in = time_ff;
               speed_in     = '0;
               yaw_in       = '0;
            end
            KIND_MOVE: begin
               started_in   = 1'b1;
               last_time_in = time_ff;
               pos_x_in     = px_ff;
               pos_y_in     = py_ff;
               head_in      = headn_ff;
               speed_in     = speed_new;
               yaw_in       = yaw_new;
            end
            default: begin
               started_in = started_ff;
            end
         endcase
      end
      rsp_valid_in = fin_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // Gain registers; the user must write them only while the block is idle, which the block itself does not enforce.
   always_comb begin
      lag_in = lag_ff;
      rag_in = rag_ff;
      ltg_in = ltg_ff;
      rtg_in = rtg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LEFT_ARC:   lag_in = csr_wdata;
            CSR_RIGHT_ARC:  rag_in = csr_wdata;
            CSR_LEFT_TURN:  ltg_in = csr_wdata;
            CSR_RIGHT_TURN: rtg_in = csr_wdata;
            default:        lag_in = lag_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      vl_ff    <= vl_in;
      vr_ff    <= vr_in;
      time_ff  <= time_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      nh_ff    <= nh_in;
      dneg_ff  <= dneg_in;
      adt_ff   <= adt_in;
      v_ff     <= v_in;
      w_ff     <= w_in;
      headn_ff <= headn_in;
      ang_ff   <= ang_in;
      dist_ff  <= dist_in;
      cmag_ff  <= cmag_in;
      smag_ff  <= smag_in;
      cneg_ff  <= cneg_in;
      sneg_ff  <= sneg_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      op_ff    <= op_in;
      kind_ff  <= kind_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         cor_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lag_ff       <= LEFT_ARC_RST;
         rag_ff       <= RIGHT_ARC_RST;
         ltg_ff       <= LEFT_TURN_RST;
         rtg_ff       <= RIGHT_TURN_RST;
         pos_x_ff     <= POS_X_RST;
         pos_y_ff     <= POS_Y_RST;
         head_ff      <= HEADING_RST;
         speed_ff     <= '0;
         yaw_ff       <= '0;
         last_time_ff <= '0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_start_ff <= mul_start_in;
         div_start_ff <= div_start_in;
         cor_start_ff <= cor_start_in;
         rsp_valid_ff <= rsp_valid_in;
         lag_ff       <= lag_in;
         rag_ff       <= rag_in;
         ltg_ff       <= ltg_in;
         rtg_ff       <= rtg_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         head_ff      <= head_in;
         speed_ff     <= speed_in;
         yaw_ff       <= yaw_in;
         last_time_ff <= last_time_in;
         started_ff   <= started_in;
      end
   end

   odo_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .done    (mul_done),
      .product (mul_prod)
   );

   odo_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .numer (mul_prod[DIV_N_W-1:0]),
      .done  (div_done),
      .quot  (div_quot)
   );

   odo_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start_ff),
      .angle   (ang_ff),
      .done    (cor_done),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   assign req_ready          = (state_ff == ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pose_x         = pos_x_ff;
   assign rsp_pose_y         = pos_y_ff;
   assign rsp_heading        = head_ff;
   assign rsp_speed          = speed_ff;
   assign rsp_yaw_rate       = yaw_ff;
   assign rsp_update_time_ms = last_time_ff;

endmodule
